@@ rtl/core/env_sensor_compensation_unit_assert.svh @@
// Assertion macros for the environmental sensor compensation unit.
// Included by the top level; relies on i_clk and i_rst_n in the including module.
`ifndef ENV_SENSOR_COMPENSATION_UNIT_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ESC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("compensation unit check failed");
`define ESC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("compensation unit check failed");
`else
`define ESC_ASSERT_IMP(label, ante, cons)
`define ESC_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ rtl/core/esc_pkg.sv @@
// Shared types, constants and helper functions for the compensation unit.
// No dependencies.
package esc_pkg;

    typedef enum logic [2:0] {
        CFG_CAL_TEMP    = 3'd0,
        CFG_CAL_PRESS_A = 3'd1,
        CFG_CAL_PRESS_B = 3'd2,
        CFG_CAL_PRESS_C = 3'd3,
        CFG_CAL_HUM     = 3'd4
    } t_cfg_idx;

    localparam int DIV_STEPS = 64;
    localparam int DIV_W     = 31;

    localparam logic [28:0] C_T_ROUND   = 29'd128;
    localparam logic [63:0] C_P_OFS     = 64'd128000;
    localparam logic [63:0] C_P_FULL    = 64'd1048576;
    localparam logic [63:0] C_P_SCALE   = 64'd3125;
    localparam logic [63:0] C_P_BIAS    = 64'd1 << 47;
    localparam logic [31:0] C_H_OFS     = 32'd76800;
    localparam logic [31:0] C_H_A_RND   = 32'd16384;
    localparam logic [31:0] C_H_C_OFS   = 32'd32768;
    localparam logic [31:0] C_H_E_OFS   = 32'd2097152;
    localparam logic [31:0] C_H_E_RND   = 32'd8192;
    localparam logic [31:0] C_H_MAX     = 32'd419430400;

    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] lh;
        logic [31:0] hl;
    } t_mul_parts;

    function automatic t_mul_parts mul_parts(input logic [63:0] a, input logic [63:0] b);
        t_mul_parts m;
        m.ll = 64'(a[31:0]) * 64'(b[31:0]);
        m.lh = a[31:0] * b[63:32];
        m.hl = a[63:32] * b[31:0];
        return m;
    endfunction

    function automatic logic [63:0] mul_join(input t_mul_parts m);
        return m.ll + {m.lh + m.hl, 32'd0};
    endfunction

endpackage

@@ rtl/core/env_sensor_compensation_unit.sv @@
// Environmental sensor compensation unit, fully pipelined top level.
// Depends on esc_pkg and env_sensor_compensation_unit_assert.svh.
//
// A reading is taken at a clock edge where start is high and busy is low;
// busy is low whenever reset is released, so one reading can enter in
// every cycle. The calibration registers are written through i_cfg_we,
// i_cfg_idx and i_cfg_wdata; the user must do so only while no transaction
// is in flight, as the block does not enforce it. Each result is shown for
// one cycle with o_strobe high; results leave in the order readings entered.
// The rate is one transaction per cycle. The pipeline depth is set by the
// 64-step restoring divider for pressure (one quotient bit per stage) plus
// the multiplier stages around it. Reset clears all valid bits and the
// calibration registers; readings in flight are dropped. The receiver
// cannot stall, so the pipeline never holds.
`include "env_sensor_compensation_unit_assert.svh"

module env_sensor_compensation_unit
    import esc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [19:0]        i_raw_pressure,
    input  logic [19:0]        i_raw_temperature,
    input  logic [15:0]        i_raw_humidity,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_wdata,
    output logic               o_strobe,
    output logic signed [31:0] o_temperature_centi,
    output logic [31:0]        o_pressure_q24_8,
    output logic [16:0]        o_humidity_q22_10,
    output logic               o_status
);

    localparam int ST_DIV0 = 12;
    localparam int ST_Q    = ST_DIV0 + DIV_STEPS + 1;
    localparam int ST_OUT  = ST_Q + 6;
    localparam int L_TEMP  = ST_OUT - 5;
    localparam int L_HUM   = ST_OUT - 16;
    localparam int L_ZERO  = ST_OUT - ST_DIV0;

    logic [47:0] r_cal_temp;
    logic [63:0] r_cal_press_a;
    logic [63:0] r_cal_press_b;
    logic [15:0] r_cal_press_c;
    logic [63:0] r_cal_hum;

    logic [ST_OUT:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_temp    <= '0;
            r_cal_press_a <= '0;
            r_cal_press_b <= '0;
            r_cal_press_c <= '0;
            r_cal_hum     <= '0;
            r_vld         <= '0;
        end else begin
            r_vld <= {r_vld[ST_OUT-1:0], start & ~busy};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CAL_TEMP:    r_cal_temp    <= i_cfg_wdata[47:0];
                    CFG_CAL_PRESS_A: r_cal_press_a <= i_cfg_wdata;
                    CFG_CAL_PRESS_B: r_cal_press_b <= i_cfg_wdata;
                    CFG_CAL_PRESS_C: r_cal_press_c <= i_cfg_wdata[15:0];
                    CFG_CAL_HUM:     r_cal_hum     <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    assign busy = ~i_rst_n;

    // Calibration coefficient fields.
    logic        [15:0] w_t1;
    logic signed [15:0] w_t2;
    logic signed [15:0] w_t3;
    logic [63:0] w_p1, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    logic [31:0] w_h1, w_h2, w_h3, w_h4, w_h5, w_h6;

    assign w_t1 = r_cal_temp[15:0];
    assign w_t2 = $signed(r_cal_temp[31:16]);
    assign w_t3 = $signed(r_cal_temp[47:32]);
    assign w_p1 = {48'd0, r_cal_press_a[15:0]};
    assign w_p2 = {{48{r_cal_press_a[31]}}, r_cal_press_a[31:16]};
    assign w_p3 = {{48{r_cal_press_a[47]}}, r_cal_press_a[47:32]};
    assign w_p4 = {{48{r_cal_press_a[63]}}, r_cal_press_a[63:48]};
    assign w_p5 = {{48{r_cal_press_b[15]}}, r_cal_press_b[15:0]};
    assign w_p6 = {{48{r_cal_press_b[31]}}, r_cal_press_b[31:16]};
    assign w_p7 = {{48{r_cal_press_b[47]}}, r_cal_press_b[47:32]};
    assign w_p8 = {{48{r_cal_press_b[63]}}, r_cal_press_b[63:48]};
    assign w_p9 = {{48{r_cal_press_c[15]}}, r_cal_press_c};
    assign w_h1 = {24'd0, r_cal_hum[7:0]};
    assign w_h2 = {{16{r_cal_hum[23]}}, r_cal_hum[23:8]};
    assign w_h3 = {24'd0, r_cal_hum[31:24]};
    assign w_h4 = {{20{r_cal_hum[43]}}, r_cal_hum[43:32]};
    assign w_h5 = {{20{r_cal_hum[55]}}, r_cal_hum[55:44]};
    assign w_h6 = {{24{r_cal_hum[63]}}, r_cal_hum[63:56]};

    // Stage 0: input capture and raw value carry.
    logic [19:0] r_raw_p;
    logic [19:0] r_raw_t;
    logic [15:0] r_raw_h;
    logic [19:0] r_adcp_dly [0:8];
    logic [15:0] r_adch_dly [0:4];

    always_ff @(posedge i_clk) begin
        r_raw_p <= i_raw_pressure;
        r_raw_t <= i_raw_temperature;
        r_raw_h <= i_raw_humidity;
        r_adcp_dly[0] <= r_raw_p;
        r_adch_dly[0] <= r_raw_h;
        for (int i = 1; i < 9; i++) begin
            r_adcp_dly[i] <= r_adcp_dly[i-1];
        end
        for (int i = 1; i < 5; i++) begin
            r_adch_dly[i] <= r_adch_dly[i-1];
        end
    end

    // Stages 1 to 4: fine temperature and temperature result.
    logic signed [17:0] n_t_a;
    logic signed [16:0] n_t_d;
    logic signed [33:0] r_t1_m;
    logic signed [33:0] r_t1_dd;
    logic signed [22:0] r_t2_v1;
    logic signed [37:0] r_t2_m;
    logic signed [25:0] r_t3_tf;
    logic signed [28:0] n_t5;
    logic signed [31:0] r_t4_temp;
    logic [63:0]        r_t4_x;
    logic [31:0]        r_t4_hv;

    assign n_t_a = $signed({1'b0, r_raw_t[19:3]}) - $signed({1'b0, w_t1, 1'b0});
    assign n_t_d = $signed({1'b0, r_raw_t[19:4]}) - $signed({1'b0, w_t1});
    assign n_t5  = 29'(r_t3_tf) * 29'sd5 + $signed(C_T_ROUND);

    always_ff @(posedge i_clk) begin
        r_t1_m    <= n_t_a * w_t2;
        r_t1_dd   <= n_t_d * n_t_d;
        r_t2_v1   <= $signed(r_t1_m[33:11]);
        r_t2_m    <= $signed(r_t1_dd[33:12]) * w_t3;
        r_t3_tf   <= r_t2_v1 + $signed(r_t2_m[37:14]);
        r_t4_temp <= 32'($signed(n_t5[28:8]));
        r_t4_x    <= 64'(r_t3_tf) - C_P_OFS;
        r_t4_hv   <= 32'(r_t3_tf) - C_H_OFS;
    end

    // Stages 5 to 11: pressure terms, numerator and divisor.
    t_mul_parts  r_p5_xx, r_p5_xp5, r_p5_xp2;
    logic [63:0] r_p6_xx, r_p6_xp5, r_p6_xp2;
    t_mul_parts  r_p7_a6, r_p7_a3;
    logic [63:0] r_p7_xp5, r_p7_xp2;
    logic [63:0] r_p8_xxp6, r_p8_xxp3, r_p8_xp5, r_p8_xp2;
    logic [63:0] r_p9_v2, r_p9_a;
    logic [63:0] n_p_nb;
    t_mul_parts  r_p10_ap1, r_p10_num;
    logic [63:0] r_p11_dv, r_p11_num;

    assign n_p_nb = ((C_P_FULL - 64'(r_adcp_dly[8])) << 31) - r_p9_v2;

    always_ff @(posedge i_clk) begin
        r_p5_xx   <= mul_parts(r_t4_x, r_t4_x);
        r_p5_xp5  <= mul_parts(r_t4_x, w_p5);
        r_p5_xp2  <= mul_parts(r_t4_x, w_p2);
        r_p6_xx   <= mul_join(r_p5_xx);
        r_p6_xp5  <= mul_join(r_p5_xp5);
        r_p6_xp2  <= mul_join(r_p5_xp2);
        r_p7_a6   <= mul_parts(r_p6_xx, w_p6);
        r_p7_a3   <= mul_parts(r_p6_xx, w_p3);
        r_p7_xp5  <= r_p6_xp5;
        r_p7_xp2  <= r_p6_xp2;
        r_p8_xxp6 <= mul_join(r_p7_a6);
        r_p8_xxp3 <= mul_join(r_p7_a3);
        r_p8_xp5  <= r_p7_xp5;
        r_p8_xp2  <= r_p7_xp2;
        r_p9_v2   <= r_p8_xxp6 + (r_p8_xp5 << 17) + (w_p4 << 35);
        r_p9_a    <= 64'($signed(r_p8_xxp3) >>> 8) + (r_p8_xp2 << 12) + C_P_BIAS;
        r_p10_ap1 <= mul_parts(r_p9_a, w_p1);
        r_p10_num <= mul_parts(n_p_nb, C_P_SCALE);
        r_p11_dv  <= 64'($signed(mul_join(r_p10_ap1)) >>> 33);
        r_p11_num <= mul_join(r_p10_num);
    end

    // Stage 12 and the divider stages: restoring division on magnitudes.
    logic [DIV_W-1:0] r_dv_rem [0:DIV_STEPS];
    logic [63:0]      r_dv_nq  [0:DIV_STEPS];
    logic [DIV_W-1:0] r_dv_ad  [0:DIV_STEPS];
    logic             r_dv_neg [0:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        r_dv_rem[0] <= '0;
        r_dv_nq[0]  <= r_p11_num[63] ? (~r_p11_num + 64'd1) : r_p11_num;
        r_dv_ad[0]  <= r_p11_dv[63] ? DIV_W'(~r_p11_dv + 64'd1) : DIV_W'(r_p11_dv);
        r_dv_neg[0] <= r_p11_num[63] ^ r_p11_dv[63];
        for (int k = 0; k < DIV_STEPS; k++) begin
            if ({r_dv_rem[k], r_dv_nq[k][63]} >= {1'b0, r_dv_ad[k]}) begin
                r_dv_rem[k+1] <= DIV_W'({r_dv_rem[k], r_dv_nq[k][63]} - {1'b0, r_dv_ad[k]});
                r_dv_nq[k+1]  <= {r_dv_nq[k][62:0], 1'b1};
            end else begin
                r_dv_rem[k+1] <= {r_dv_rem[k][DIV_W-2:0], r_dv_nq[k][63]};
                r_dv_nq[k+1]  <= {r_dv_nq[k][62:0], 1'b0};
            end
            r_dv_ad[k+1]  <= r_dv_ad[k];
            r_dv_neg[k+1] <= r_dv_neg[k];
        end
    end

    // Post-division pressure correction and saturation.
    logic [63:0] r_q;
    t_mul_parts  r_pq1_dd, r_pq1_p8;
    logic [63:0] r_pq1_q;
    logic [63:0] r_pq2_dd, r_pq2_p8, r_pq2_q;
    t_mul_parts  r_pq3_ddp9;
    logic [63:0] r_pq3_v2, r_pq3_q;
    logic [63:0] r_pq4_v1, r_pq4_v2, r_pq4_q;
    logic [63:0] r_pq5_sum;
    logic [63:0] n_pd;
    logic [63:0] n_pfin;

    assign n_pd   = 64'($signed(r_q) >>> 13);
    assign n_pfin = 64'($signed(r_pq5_sum) >>> 8) + (w_p7 << 4);

    always_ff @(posedge i_clk) begin
        r_q        <= r_dv_neg[DIV_STEPS] ? (~r_dv_nq[DIV_STEPS] + 64'd1) : r_dv_nq[DIV_STEPS];
        r_pq1_dd   <= mul_parts(n_pd, n_pd);
        r_pq1_p8   <= mul_parts(w_p8, r_q);
        r_pq1_q    <= r_q;
        r_pq2_dd   <= mul_join(r_pq1_dd);
        r_pq2_p8   <= mul_join(r_pq1_p8);
        r_pq2_q    <= r_pq1_q;
        r_pq3_ddp9 <= mul_parts(r_pq2_dd, w_p9);
        r_pq3_v2   <= 64'($signed(r_pq2_p8) >>> 19);
        r_pq3_q    <= r_pq2_q;
        r_pq4_v1   <= 64'($signed(mul_join(r_pq3_ddp9)) >>> 25);
        r_pq4_v2   <= r_pq3_v2;
        r_pq4_q    <= r_pq3_q;
        r_pq5_sum  <= r_pq4_q + r_pq4_v1 + r_pq4_v2;
    end

    // Stages 5 to 15: humidity in 32-bit wrapping arithmetic.
    logic [31:0] r_h5_h5v, r_h5_vh6, r_h5_vh3;
    logic [31:0] n_h_a;
    logic [31:0] r_h6_a, r_h6_b, r_h6_c;
    logic [31:0] r_h7_bc, r_h7_a;
    logic [31:0] r_h8_e1, r_h8_a;
    logic [31:0] r_h9_eh2, r_h9_a;
    logic [31:0] r_h10_e2, r_h10_a;
    logic [31:0] r_h11_v;
    logic [31:0] r_h12_s, r_h12_v;
    logic [31:0] r_h13_ss, r_h13_v;
    logic [31:0] r_h14_sh1, r_h14_v;
    logic [31:0] n_h_d;
    logic [31:0] n_h_clamp;
    logic [16:0] r_h15_hum;

    assign n_h_a = {2'd0, r_adch_dly[4], 14'd0} - (w_h4 << 20) - r_h5_h5v + C_H_A_RND;
    assign n_h_d = r_h14_v - 32'($signed(r_h14_sh1) >>> 4);

    always_comb begin
        if (n_h_d[31]) begin
            n_h_clamp = '0;
        end else if (n_h_d > C_H_MAX) begin
            n_h_clamp = C_H_MAX;
        end else begin
            n_h_clamp = n_h_d;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h5_h5v  <= w_h5 * r_t4_hv;
        r_h5_vh6  <= r_t4_hv * w_h6;
        r_h5_vh3  <= r_t4_hv * w_h3;
        r_h6_a    <= 32'($signed(n_h_a) >>> 15);
        r_h6_b    <= 32'($signed(r_h5_vh6) >>> 10);
        r_h6_c    <= 32'($signed(r_h5_vh3) >>> 11) + C_H_C_OFS;
        r_h7_bc   <= r_h6_b * r_h6_c;
        r_h7_a    <= r_h6_a;
        r_h8_e1   <= 32'($signed(r_h7_bc) >>> 10) + C_H_E_OFS;
        r_h8_a    <= r_h7_a;
        r_h9_eh2  <= r_h8_e1 * w_h2;
        r_h9_a    <= r_h8_a;
        r_h10_e2  <= 32'($signed(r_h9_eh2 + C_H_E_RND) >>> 14);
        r_h10_a   <= r_h9_a;
        r_h11_v   <= r_h10_a * r_h10_e2;
        r_h12_s   <= 32'($signed(r_h11_v) >>> 15);
        r_h12_v   <= r_h11_v;
        r_h13_ss  <= r_h12_s * r_h12_s;
        r_h13_v   <= r_h12_v;
        r_h14_sh1 <= 32'($signed(r_h13_ss) >>> 7) * w_h1;
        r_h14_v   <= r_h13_v;
        r_h15_hum <= n_h_clamp[28:12];
    end

    // Delay lines that align temperature, humidity and the divisor flag.
    logic signed [31:0] r_temp_dly [0:L_TEMP-1];
    logic [16:0]        r_hum_dly  [0:L_HUM-1];
    logic               r_zero_dly [0:L_ZERO-1];

    always_ff @(posedge i_clk) begin
        r_temp_dly[0] <= r_t4_temp;
        r_hum_dly[0]  <= r_h15_hum;
        r_zero_dly[0] <= (r_p11_dv == 64'd0);
        for (int i = 1; i < L_TEMP; i++) begin
            r_temp_dly[i] <= r_temp_dly[i-1];
        end
        for (int i = 1; i < L_HUM; i++) begin
            r_hum_dly[i] <= r_hum_dly[i-1];
        end
        for (int i = 1; i < L_ZERO; i++) begin
            r_zero_dly[i] <= r_zero_dly[i-1];
        end
    end

    // Output register.
    logic signed [31:0] r_out_temp;
    logic [31:0]        r_out_press;
    logic [16:0]        r_out_hum;
    logic               r_out_status;

    always_ff @(posedge i_clk) begin
        r_out_temp <= r_temp_dly[L_TEMP-1];
        if (r_zero_dly[L_ZERO-1]) begin
            r_out_press  <= '0;
            r_out_hum    <= '0;
            r_out_status <= 1'b1;
        end else begin
            r_out_hum    <= r_hum_dly[L_HUM-1];
            r_out_status <= 1'b0;
            if (n_pfin[63]) begin
                r_out_press <= '0;
            end else if (|n_pfin[62:32]) begin
                r_out_press <= '1;
            end else begin
                r_out_press <= n_pfin[31:0];
            end
        end
    end

    assign o_strobe            = r_vld[ST_OUT];
    assign o_temperature_centi = r_out_temp;
    assign o_pressure_q24_8    = r_out_press;
    assign o_humidity_q22_10   = r_out_hum;
    assign o_status            = r_out_status;

    `ESC_ASSERT_NXT(a_latency, start, ##(ST_OUT) o_strobe)
    `ESC_ASSERT_IMP(a_div_rem, r_vld[ST_Q-1] && (r_dv_ad[DIV_STEPS] != '0), r_dv_rem[DIV_STEPS] < r_dv_ad[DIV_STEPS])
    `ESC_ASSERT_IMP(a_err_zero, o_strobe && o_status, (o_pressure_q24_8 == '0) && (o_humidity_q22_10 == '0))

endmodule
